FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ps2mpt_pkg.sv
`timescale 1ns / 1ps
package ps2mpt_pkg;

   localparam int POS_WIDTH_DEF = 12;

   // register indexes on the csr port
   localparam logic [1:0] REG_ENABLE  = 2'd0;
   localparam logic [1:0] REG_X_LIMIT = 2'd1;
   localparam logic [1:0] REG_Y_LIMIT = 2'd2;

   localparam int X_LIMIT_RST = 640;
   localparam int Y_LIMIT_RST = 480;
   localparam int CURSOR_X_RST = 320;
   localparam int CURSOR_Y_RST = 240;

   // packet phase codes
   localparam logic [1:0] PH_FLAGS = 2'd0;
   localparam logic [1:0] PH_X     = 2'd1;
   localparam logic [1:0] PH_Y     = 2'd2;

   localparam logic [7:0] BYTE_MASK = 8'hff;

   // flags byte bit positions
   localparam int FB_LEFT   = 0;
   localparam int FB_RIGHT  = 1;
   localparam int FB_MIDDLE = 2;
   localparam int FB_ONE    = 3;
   localparam int FB_XSIGN  = 4;
   localparam int FB_YSIGN  = 5;
   localparam int FB_XOVF   = 6;
   localparam int FB_YOVF   = 7;

endpackage

FILE: rtl/ps2_mouse_packet_tracker_top.sv
`timescale 1ns / 1ps
// PS/2 mouse packet tracker.
// req_ channel: one mouse byte per request (req_rx_byte), valid/stall handshake.
// rsp_ channel: one result per completed three-byte packet: cursor position,
//   the three latched buttons and an overflow-dropped flag.
// csr_ channel: register writes (index 0 enable, 1 x_limit, 2 y_limit);
//   csr_ready is always high, other indexes are ignored.
// Bytes arriving while enable is low are consumed and change nothing.
// Path: an accepted byte is held in the input register and processed from there;
//   processing the third byte loads the cursor state and the result register.
// Throughput: one byte per cycle while no result is held stalled, set by the single
//   input register feeding the tracker update; the cursor add and clamp are combinational.
// Stall: a waiting result is held in the output register; bytes keep flowing
//   through the input register meanwhile. req_stall rises only when the held
//   byte would complete a packet and the result register is still occupied and stalled.
// Reset (synchronous, active high): enable 0, limits 640/480, cursor 320/240,
//   buttons released, phase waiting for a flags byte, both registers empty.
module ps2_mouse_packet_tracker_top #(
   parameter int POS_WIDTH = ps2mpt_pkg::POS_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // byte requests
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   // results
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [POS_WIDTH-1:0] rsp_pos_x,
   output logic [POS_WIDTH-1:0] rsp_pos_y,
   output logic                 rsp_button_left,
   output logic                 rsp_button_middle,
   output logic                 rsp_button_right,
   output logic                 rsp_overflow_dropped,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [POS_WIDTH-1:0] csr_wdata
);

   localparam int SUM_W = POS_WIDTH + 2;

   // configuration
   logic                 enable_ff;
   logic [POS_WIDTH-1:0] x_limit_ff, y_limit_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // tracker state
   logic [1:0]           phase_ff, phase_in;
   logic [7:0]           flags_ff, flags_in;
   logic [7:0]           x_byte_ff, x_byte_in;
   logic [POS_WIDTH-1:0] cur_x_ff, cur_x_in;
   logic [POS_WIDTH-1:0] cur_y_ff, cur_y_in;
   logic [2:0]           buttons_ff, buttons_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 dropped_ff;

   logic req_accept, out_free, makes_result, process_go, rsp_load, ovf;
   logic signed [9:0]    dx, dy;
   logic [POS_WIDTH-1:0] clamp_x, clamp_y;

   // Move a position by a signed delta and clamp it to 0..limit.
   function automatic logic [POS_WIDTH-1:0] clamp_pos(
      input logic [POS_WIDTH-1:0] cur,
      input logic signed [9:0]    delta,
      input logic [POS_WIDTH-1:0] limit
   );
      logic signed [SUM_W-1:0] v;
      logic signed [SUM_W-1:0] lim;
      logic [POS_WIDTH-1:0]    res;
      v   = $signed({2'b00, cur}) + SUM_W'(delta);
      lim = $signed({2'b00, limit});
      if (v < 0) begin
         res = '0;
      end else if (v > lim) begin
         res = limit;
      end else begin
         res = v[POS_WIDTH-1:0];
      end
      return res;
   endfunction

   assign csr_ready = 1'b1;

   assign req_accept   = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   // only the Y byte of an enabled packet needs room in the result register
   assign makes_result = enable_ff && (phase_ff == ps2mpt_pkg::PH_Y);
   assign process_go   = in_valid_ff && (!makes_result || out_free);
   assign rsp_load     = process_go && makes_result;
   assign req_stall    = in_valid_ff && !process_go;

   assign in_valid_in = req_accept ? 1'b1 : (process_go ? 1'b0 : in_valid_ff);

   // 9-bit deltas, Y negated so down is positive
   assign dx = {flags_ff[ps2mpt_pkg::FB_XSIGN], flags_ff[ps2mpt_pkg::FB_XSIGN], x_byte_ff};
   assign dy = -$signed({flags_ff[ps2mpt_pkg::FB_YSIGN], flags_ff[ps2mpt_pkg::FB_YSIGN],
                         in_byte_ff});
   assign ovf = flags_ff[ps2mpt_pkg::FB_XOVF] || flags_ff[ps2mpt_pkg::FB_YOVF];

   assign clamp_x = clamp_pos(cur_x_ff, dx, x_limit_ff);
   assign clamp_y = clamp_pos(cur_y_ff, dy, y_limit_ff);

   always_comb begin
      phase_in   = phase_ff;
      flags_in   = flags_ff;
      x_byte_in  = x_byte_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      buttons_in = buttons_ff;
      if (process_go && enable_ff) begin
         unique case (phase_ff)
            ps2mpt_pkg::PH_X: begin
               x_byte_in = in_byte_ff & ps2mpt_pkg::BYTE_MASK;
               phase_in  = ps2mpt_pkg::PH_Y;
            end
            ps2mpt_pkg::PH_Y: begin
               phase_in = ps2mpt_pkg::PH_FLAGS;
               if (!ovf) begin
                  cur_x_in   = clamp_x;
                  cur_y_in   = clamp_y;
                  buttons_in = flags_ff[2:0];
               end
            end
            default: begin
               // waiting for a flags byte; the unused code behaves the same
               if (in_byte_ff[ps2mpt_pkg::FB_ONE]) begin
                  flags_in = in_byte_ff;
                  phase_in = ps2mpt_pkg::PH_X;
               end else begin
                  phase_in = ps2mpt_pkg::PH_FLAGS;
               end
            end
         endcase
      end
   end

   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         x_limit_ff   <= POS_WIDTH'(ps2mpt_pkg::X_LIMIT_RST);
         y_limit_ff   <= POS_WIDTH'(ps2mpt_pkg::Y_LIMIT_RST);
         in_valid_ff  <= 1'b0;
         phase_ff     <= ps2mpt_pkg::PH_FLAGS;
         flags_ff     <= '0;
         x_byte_ff    <= '0;
         cur_x_ff     <= POS_WIDTH'(ps2mpt_pkg::CURSOR_X_RST);
         cur_y_ff     <= POS_WIDTH'(ps2mpt_pkg::CURSOR_Y_RST);
         buttons_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ps2mpt_pkg::REG_ENABLE:  enable_ff  <= csr_wdata[0];
               ps2mpt_pkg::REG_X_LIMIT: x_limit_ff <= csr_wdata;
               ps2mpt_pkg::REG_Y_LIMIT: y_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         x_byte_ff    <= x_byte_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         buttons_ff   <= buttons_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (rsp_load) begin
         dropped_ff <= ovf;
      end
   end

   // the result shows the state registers, which only change on the next load
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pos_x            = cur_x_ff;
   assign rsp_pos_y            = cur_y_ff;
   assign rsp_button_left      = buttons_ff[ps2mpt_pkg::FB_LEFT];
   assign rsp_button_right     = buttons_ff[ps2mpt_pkg::FB_RIGHT];
   assign rsp_button_middle    = buttons_ff[ps2mpt_pkg::FB_MIDDLE];
   assign rsp_overflow_dropped = dropped_ff;

endmodule

FILE: rtl/ps2mpt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ps2mpt_checker #(
   parameter int POS_WIDTH = ps2mpt_pkg::POS_WIDTH_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [POS_WIDTH-1:0] rsp_pos_x,
   input logic [POS_WIDTH-1:0] rsp_pos_y,
   input logic                 rsp_button_left,
   input logic                 rsp_button_middle,
   input logic                 rsp_button_right,
   input logic                 rsp_overflow_dropped
);

   logic                   rsp_held;
   logic [2*POS_WIDTH+3:0] rsp_payload;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_pos_x, rsp_pos_y, rsp_button_left, rsp_button_middle,
                         rsp_button_right, rsp_overflow_dropped};

   // back-pressure only comes from a full result register that is stalled
   `CHK_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_held, "req_stall without held result")
   // result register comes out of reset empty
   `CHK_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")
   // a stalled result stays offered
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid, "result dropped while stalled")
   // and its payload holds
   `CHK_ASSERT(a_rsp_stable, clock, reset, rsp_held |=> $stable(rsp_payload), "stalled result changed")

endmodule

bind ps2_mouse_packet_tracker_top ps2mpt_checker #(.POS_WIDTH(POS_WIDTH)) u_ps2mpt_checker (.*);

FILE: dv/ps2_mouse_packet_tracker_top_test.sv
`timescale 1ns / 1ps
module ps2_mouse_packet_tracker_top_test;

   localparam int POSW = ps2mpt_pkg::POS_WIDTH_DEF;
   localparam int SETTLE_CYCLES = 4;     // pause after the last report, letting the pipe empty
   localparam int DRAIN_LIMIT = 5000;    // bound on waiting for outstanding reports
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // one report per completed packet
   typedef struct packed {
      logic [POSW-1:0] pos_x;
      logic [POSW-1:0] pos_y;
      logic            left;
      logic            middle;
      logic            right;
      logic            dropped;
   } cursor_report_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [7:0]      req_rx_byte = 8'h00;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [POSW-1:0] rsp_pos_x;
   logic [POSW-1:0] rsp_pos_y;
   logic            rsp_button_left;
   logic            rsp_button_middle;
   logic            rsp_button_right;
   logic            rsp_overflow_dropped;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = ps2mpt_pkg::REG_ENABLE;
   logic [POSW-1:0] csr_wdata = '0;

   // tracker state as the block should hold it
   logic            trk_enable = 1'b0;
   logic [POSW-1:0] trk_x_limit = POSW'(ps2mpt_pkg::X_LIMIT_RST);
   logic [POSW-1:0] trk_y_limit = POSW'(ps2mpt_pkg::Y_LIMIT_RST);
   logic [1:0]      trk_phase = ps2mpt_pkg::PH_FLAGS;
   logic [7:0]      trk_flags = 8'h00;
   logic [7:0]      trk_xbyte = 8'h00;
   logic [POSW-1:0] trk_cur_x = POSW'(ps2mpt_pkg::CURSOR_X_RST);
   logic [POSW-1:0] trk_cur_y = POSW'(ps2mpt_pkg::CURSOR_Y_RST);
   logic [2:0]      trk_buttons = 3'b000;   // bit0 left, bit1 right, bit2 middle

   cursor_report_type pending_reports[$];
   int mismatches = 0;
   int sender_idle = 35;     // percent of cycles the request side holds back
   int receiver_idle = 50;   // percent of cycles the report side stalls

   ps2_mouse_packet_tracker_top #(.POS_WIDTH(POSW)) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_button_left      (rsp_button_left),
      .rsp_button_middle    (rsp_button_middle),
      .rsp_button_right     (rsp_button_right),
      .rsp_overflow_dropped (rsp_overflow_dropped),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------
   // Cursor tracking
   // ---------------------------------------------------------------

   // move one axis and hold it inside 0..limit
   function automatic logic [POSW-1:0] clamp_axis(input logic [POSW-1:0] cur, input int delta,
                                                  input logic [POSW-1:0] lim);
      int v;
      v = int'(cur) + delta;
      if (v > int'(lim)) v = int'(lim);
      if (v < 0) v = 0;
      return v[POSW-1:0];
   endfunction

   // frame one accepted byte; a finished packet queues its report
   function automatic void track_byte(input logic [7:0] b);
      int dx;
      int dy;
      cursor_report_type rep;
      if (!trk_enable) return;   // disabled: byte consumed, phase kept
      case (trk_phase)
         ps2mpt_pkg::PH_X: begin
            trk_xbyte = b;
            trk_phase = ps2mpt_pkg::PH_Y;
         end
         ps2mpt_pkg::PH_Y: begin
            trk_phase = ps2mpt_pkg::PH_FLAGS;
            rep.dropped = trk_flags[ps2mpt_pkg::FB_XOVF] | trk_flags[ps2mpt_pkg::FB_YOVF];
            if (!rep.dropped) begin
               // 9-bit deltas; Y flips so that down counts positive
               dx = int'(trk_xbyte) - (trk_flags[ps2mpt_pkg::FB_XSIGN] ? 256 : 0);
               dy = (trk_flags[ps2mpt_pkg::FB_YSIGN] ? 256 : 0) - int'(b);
               trk_cur_x = clamp_axis(trk_cur_x, dx, trk_x_limit);
               trk_cur_y = clamp_axis(trk_cur_y, dy, trk_y_limit);
               trk_buttons = {trk_flags[ps2mpt_pkg::FB_MIDDLE],
                              trk_flags[ps2mpt_pkg::FB_RIGHT],
                              trk_flags[ps2mpt_pkg::FB_LEFT]};
            end
            rep.pos_x  = trk_cur_x;
            rep.pos_y  = trk_cur_y;
            rep.left   = trk_buttons[0];
            rep.right  = trk_buttons[1];
            rep.middle = trk_buttons[2];
            pending_reports.push_back(rep);
         end
         default: begin
            // flags byte must carry its always-one bit, otherwise skip it
            if (b[ps2mpt_pkg::FB_ONE]) begin
               trk_flags = b;
               trk_phase = ps2mpt_pkg::PH_X;
            end else begin
               trk_phase = ps2mpt_pkg::PH_FLAGS;
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Report checking and receiver stalls
   // ---------------------------------------------------------------

   function automatic string report_text(input cursor_report_type r);
      return $sformatf("x=%0d y=%0d left=%b middle=%b right=%b dropped=%b",
                       r.pos_x, r.pos_y, r.left, r.middle, r.right, r.dropped);
   endfunction

   function automatic void check_report();
      cursor_report_type seen;
      cursor_report_type want;
      seen = {rsp_pos_x, rsp_pos_y, rsp_button_left, rsp_button_middle,
              rsp_button_right, rsp_overflow_dropped};
      if (pending_reports.size() == 0) begin
         if (mismatches < 10) $display("unexpected report: %s", report_text(seen));
         mismatches++;
      end else begin
         want = pending_reports.pop_front();
         if (seen !== want) begin
            if (mismatches < 10)
               $display("report mismatch: expected %s, got %s",
                        report_text(want), report_text(seen));
            mismatches++;
         end
      end
   endfunction

   // sample at the edge, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) check_report();
      rsp_stall <= ($urandom_range(99) < receiver_idle);
   end

   // ---------------------------------------------------------------
   // Request and register drivers
   // ---------------------------------------------------------------

   // valid is only dropped for a gap, so back-to-back requests keep it high
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      track_byte(b);
   endtask

   task automatic send_packet(input logic [7:0] flags, input logic [7:0] xb,
                              input logic [7:0] yb);
      send_byte(flags);
      send_byte(xb);
      send_byte(yb);
   endtask

   // hold requests off until every report is back, then let the pipe empty
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays up across consecutive writes; close_writes drops it
   task automatic write_reg(input logic [1:0] idx, input logic [POSW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ps2mpt_pkg::REG_ENABLE:  trk_enable = data[0];
         ps2mpt_pkg::REG_X_LIMIT: trk_x_limit = data;
         ps2mpt_pkg::REG_Y_LIMIT: trk_y_limit = data;
         default: ;
      endcase
   endtask

   task automatic close_writes();
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(input logic [POSW-1:0] xl, input logic [POSW-1:0] yl);
      settle();
      write_reg(ps2mpt_pkg::REG_X_LIMIT, xl);
      write_reg(ps2mpt_pkg::REG_Y_LIMIT, yl);
      close_writes();
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // out of reset the tracker is disabled: whole packets must vanish
   task automatic test_disabled_input();
      send_packet(8'h08, 8'h10, 8'h10);
      send_byte(8'h00);
      settle();
      write_reg(ps2mpt_pkg::REG_ENABLE, 1'b1);
      close_writes();
   endtask

   // sign handling, buttons, bad flags bytes and overflow drops at reset limits
   task automatic test_packet_decode();
      send_packet(8'h08, 8'h00, 8'h00);   // no motion, no buttons
      send_byte(8'h00);                   // always-one bit clear: skipped
      send_byte(8'hf7);
      send_packet(8'h0f, 8'hff, 8'hff);   // all buttons, +255 / screen up, y hits 0
      send_packet(8'h38, 8'h00, 8'h00);   // both deltas -256 raw
      send_packet(8'h4f, 8'h7f, 8'h7f);   // x overflow: dropped, buttons kept
      send_packet(8'h8b, 8'h01, 8'h80);   // y overflow
      send_packet(8'hff, 8'hff, 8'hff);   // everything set
      send_packet(8'h09, 8'hff, 8'h00);
      send_packet(8'h09, 8'hff, 8'h00);   // x clamps at the limit
   endtask

   // a packet cut by a disable resumes where it stopped
   task automatic test_resume_after_disable();
      send_byte(8'h0c);
      send_byte(8'h05);
      settle();
      write_reg(ps2mpt_pkg::REG_ENABLE, 1'b0);
      close_writes();
      send_byte(8'h08);
      send_byte(8'haa);
      settle();
      write_reg(ps2mpt_pkg::REG_ENABLE, 1'b1);
      close_writes();
      send_byte(8'h03);
   endtask

   // zero limits, full-range limits, and a limit lowered under the cursor
   task automatic test_limit_edges();
      set_limits('0, '0);
      send_packet(8'h08, 8'h10, 8'h10);
      set_limits('1, '1);
      repeat (17) send_packet(8'h28, 8'hff, 8'h00);   // walk both axes to the top
      set_limits(POSW'(100), POSW'(1));
      @(posedge clock);
      write_reg(REG_UNUSED, '0);                      // must not touch any limit
      close_writes();
      send_packet(8'hc8, 8'h00, 8'h00);   // dropped: still the old position
      send_packet(8'h08, 8'h00, 8'h00);   // now clamped to the new limits
   endtask

   // mostly complete packets with random content, some cut short, some noise, one disabled stretch
   task automatic test_random_traffic(input int n_items);
      int sent;
      int pick;
      bit burst_done;
      logic [7:0] flags;
      sent = 0;
      burst_done = 1'b0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         flags = 8'($urandom);
         flags[ps2mpt_pkg::FB_ONE] = 1'b1;
         if ($urandom_range(7) != 0) flags[ps2mpt_pkg::FB_YOVF:ps2mpt_pkg::FB_XOVF] = 2'b00;
         if (!burst_done && sent >= n_items / 2) begin
            // a short disabled stretch, possibly in the middle of a packet
            burst_done = 1'b1;
            settle();
            write_reg(ps2mpt_pkg::REG_ENABLE, 1'b0);
            close_writes();
            repeat ($urandom_range(6, 2)) send_byte(8'($urandom));
            settle();
            write_reg(ps2mpt_pkg::REG_ENABLE, 1'b1);
            close_writes();
         end else if (pick < 75) begin
            send_packet(flags, 8'($urandom), 8'($urandom));
            sent += 3;
         end else if (pick < 87) begin
            send_byte(flags);
            sent++;
            if (pick[0]) begin
               send_byte(8'($urandom));
               sent++;
            end
         end else begin
            send_byte(8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_disabled_input();
      test_packet_decode();
      test_resume_after_disable();
      test_limit_edges();

      set_limits(POSW'($urandom_range(4095, 1)), POSW'($urandom_range(4095, 1)));
      test_random_traffic(420);

      sender_idle = 50;
      receiver_idle = 35;
      set_limits('1, '1);
      test_random_traffic(420);

      sender_idle = 0;
      receiver_idle = 0;
      set_limits(POSW'($urandom_range(64, 1)), POSW'($urandom_range(64, 1)));
      test_random_traffic(410);

      settle();
      if (pending_reports.size() != 0) begin
         $display("reports never seen: %0d", pending_reports.size());
         mismatches += pending_reports.size();
      end
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
